// ===== rtl/mft_pkg.sv =====
// Shared constants and types of the max frequency tracker.
package mft_pkg;

    // Fixed widths of the transaction fields.
    localparam int SYMBOL_W    = 10;
    localparam int MAX_COUNT_W = 12;

    // Control bits that travel with one transaction from stage to stage.
    typedef struct packed {
        logic valid;
        logic insert;
        logic ignored;
    } mft_ctl_t;

endpackage

// ===== rtl/mft_count_stage.sv =====
// Symbol count memory with read-modify-write, forwarding and the count step.
module mft_count_stage #(
    parameter int SYMBOLS     = 1024,
    parameter int COUNT_LIMIT = 4095,
    localparam int AW         = $clog2(SYMBOLS),
    localparam int CW         = $clog2(COUNT_LIMIT + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          clr_en,
    input  logic [AW-1:0]                 clr_addr,
    input  logic                          in_valid,
    input  logic                          mode,
    input  logic [mft_pkg::SYMBOL_W-1:0]  symbol,
    output mft_pkg::mft_ctl_t             ctl,
    output logic [CW-1:0]                 c_cur,
    output logic [CW-1:0]                 c_new
);
    import mft_pkg::*;

    logic [CW-1:0] mem [SYMBOLS];

    logic          s1_valid_reg;
    logic          s1_insert_reg;
    logic          s1_oor_reg;
    logic [AW-1:0] s1_addr_reg;
    logic [CW-1:0] rd_data_reg;
    logic          byp_reg;
    logic [CW-1:0] byp_data_reg;

    logic [AW-1:0] in_addr;
    logic          in_oor;
    logic          ignored;
    logic          wr_apply;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [CW-1:0] mem_wd;

    // Address of the incoming transaction and its range check.
    assign in_addr = AW'(symbol);
    assign in_oor  = (32'(symbol) >= 32'(SYMBOLS));

    // Current count, taking the write of the previous transaction when it hit the same symbol.
    assign c_cur   = byp_reg ? byp_data_reg : rd_data_reg;

    // Step the count and decide whether the transaction is dropped.
    always_comb
    begin
        if (s1_insert_reg)
        begin
            ignored = s1_oor_reg || (c_cur >= CW'(COUNT_LIMIT));
            c_new   = c_cur + CW'(1);
        end
        else
        begin
            ignored = s1_oor_reg || (c_cur == '0);
            c_new   = c_cur - CW'(1);
        end
    end

    assign wr_apply    = s1_valid_reg && !ignored;
    assign ctl.valid   = s1_valid_reg;
    assign ctl.insert  = s1_insert_reg;
    assign ctl.ignored = ignored;

    // Write port is shared between the clearing sweep and normal updates.
    assign mem_we = clr_en || wr_apply;
    assign mem_wa = clr_en ? clr_addr : s1_addr_reg;
    assign mem_wd = clr_en ? '0 : c_new;

    // Count memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (in_valid)
        begin
            rd_data_reg <= mem[in_addr];
        end
    end

    // Stage payload; the bypass data follows the write that lands at the read edge.
    always_ff @(posedge clk)
    begin
        s1_insert_reg <= mode;
        s1_oor_reg    <= in_oor;
        s1_addr_reg   <= in_addr;
        byp_data_reg  <= c_new;
    end

    // Stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            byp_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            byp_reg      <= wr_apply && (s1_addr_reg == in_addr);
        end
    end

endmodule

// ===== rtl/mft_pop_stage.sv =====
// Count population banks (even and odd counts) and the running maximum.
module mft_pop_stage #(
    parameter int SYMBOLS     = 1024,
    parameter int COUNT_LIMIT = 4095,
    localparam int CW         = $clog2(COUNT_LIMIT + 1),
    localparam int PD         = (COUNT_LIMIT + 2) / 2,
    localparam int PAW        = (PD > 1) ? $clog2(PD) : 1,
    localparam int PW         = $clog2(SYMBOLS + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              clr_en,
    input  logic [PAW-1:0]    clr_addr,
    input  mft_pkg::mft_ctl_t ctl,
    input  logic [CW-1:0]     c_cur,
    input  logic [CW-1:0]     c_new,
    output mft_pkg::mft_ctl_t res_ctl,
    output logic [CW-1:0]     max_next
);
    import mft_pkg::*;

    // A count and its neighbor always fall in different banks.
    logic [PW-1:0] bank_e [PD];
    logic [PW-1:0] bank_o [PD];

    logic          s2_valid_reg;
    logic          s2_insert_reg;
    logic          s2_ign_reg;
    logic [CW-1:0] s2_c_reg;
    logic [CW-1:0] s2_n_reg;
    logic [PW-1:0] rd_e_reg;
    logic [PW-1:0] rd_o_reg;
    logic          byp_e_reg;
    logic          byp_o_reg;
    logic [PW-1:0] byp_e_data_reg;
    logic [PW-1:0] byp_o_data_reg;
    logic [CW-1:0] max_reg;

    logic [PAW-1:0] rd_e_addr;
    logic [PAW-1:0] rd_o_addr;
    logic [PAW-1:0] s2_c_addr;
    logic [PAW-1:0] s2_n_addr;
    logic           s2_odd;
    logic [PW-1:0]  pop_e;
    logic [PW-1:0]  pop_o;
    logic [PW-1:0]  pop_c;
    logic [PW-1:0]  pop_n;
    logic           apply;
    logic           we;
    logic [PAW-1:0] wa_e;
    logic [PAW-1:0] wa_o;
    logic [PW-1:0]  wd_e;
    logic [PW-1:0]  wd_o;

    // Read addresses: the old count and the new count, routed by parity.
    always_comb
    begin
        if (c_cur[0])
        begin
            rd_e_addr = PAW'(c_new >> 1);
            rd_o_addr = PAW'(c_cur >> 1);
        end
        else
        begin
            rd_e_addr = PAW'(c_cur >> 1);
            rd_o_addr = PAW'(c_new >> 1);
        end
    end

    // Populations seen by this transaction, with the previous write forwarded.
    assign s2_odd    = s2_c_reg[0];
    assign pop_e     = byp_e_reg ? byp_e_data_reg : rd_e_reg;
    assign pop_o     = byp_o_reg ? byp_o_data_reg : rd_o_reg;
    assign pop_c     = s2_odd ? pop_o : pop_e;
    assign pop_n     = s2_odd ? pop_e : pop_o;
    assign s2_c_addr = PAW'(s2_c_reg >> 1);
    assign s2_n_addr = PAW'(s2_n_reg >> 1);
    assign apply     = s2_valid_reg && !s2_ign_reg;

    // Bank writes: the old count loses one symbol, the new count gains one.
    always_comb
    begin
        we = clr_en || apply;
        if (clr_en)
        begin
            wa_e = clr_addr;
            wa_o = clr_addr;
            wd_e = (clr_addr == '0) ? PW'(SYMBOLS) : '0;
            wd_o = '0;
        end
        else if (s2_odd)
        begin
            wa_e = s2_n_addr;
            wa_o = s2_c_addr;
            wd_e = pop_n + PW'(1);
            wd_o = pop_c - PW'(1);
        end
        else
        begin
            wa_e = s2_c_addr;
            wa_o = s2_n_addr;
            wd_e = pop_c - PW'(1);
            wd_o = pop_n + PW'(1);
        end
    end

    // Running maximum moves up on an insert past it, down when its last holder leaves.
    always_comb
    begin
        max_next = max_reg;
        if (apply)
        begin
            if (s2_insert_reg)
            begin
                if (s2_n_reg > max_reg)
                begin
                    max_next = s2_n_reg;
                end
            end
            else if ((s2_c_reg == max_reg) && (pop_c == PW'(1)))
            begin
                max_next = max_reg - CW'(1);
            end
        end
    end

    assign res_ctl.valid   = s2_valid_reg;
    assign res_ctl.insert  = s2_insert_reg;
    assign res_ctl.ignored = s2_ign_reg;

    // Even bank.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            bank_e[wa_e] <= wd_e;
        end
        if (ctl.valid)
        begin
            rd_e_reg <= bank_e[rd_e_addr];
        end
    end

    // Odd bank.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            bank_o[wa_o] <= wd_o;
        end
        if (ctl.valid)
        begin
            rd_o_reg <= bank_o[rd_o_addr];
        end
    end

    // Stage payload and forwarded write data.
    always_ff @(posedge clk)
    begin
        s2_insert_reg  <= ctl.insert;
        s2_ign_reg     <= ctl.ignored;
        s2_c_reg       <= c_cur;
        s2_n_reg       <= c_new;
        byp_e_data_reg <= wd_e;
        byp_o_data_reg <= wd_o;
    end

    // Stage control and the maximum.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            byp_e_reg    <= 1'b0;
            byp_o_reg    <= 1'b0;
            max_reg      <= '0;
        end
        else
        begin
            s2_valid_reg <= ctl.valid;
            byp_e_reg    <= apply && (wa_e == rd_e_addr);
            byp_o_reg    <= apply && (wa_o == rd_o_addr);
            max_reg      <= max_next;
        end
    end

endmodule

// ===== rtl/max_frequency_tracker.sv =====
// Top level of the max frequency tracker: clearing sweep, stages and result register.
//
// The block keeps a multiset of symbols and reports the largest count held by any
// symbol (the frequency of the mode). A transaction is accepted on a rising edge
// with start high and busy low; mode selects insert (1) or remove (0) of symbol.
// Every accepted transaction gives exactly one result: done is high for one cycle
// with max_count and ignored, after the count stage, the population stage and the
// result register. Removal of an absent symbol, insertion at COUNT_LIMIT, or a
// symbol of SYMBOLS or above leaves the state unchanged and sets ignored.
// Throughput is one transaction per cycle while busy is low. The symbol count
// memory is read at the accepting edge and written in the next cycle; the two
// population banks (even and odd counts) are read as it is written and written in
// the cycle after that, and forwarding covers a transaction that follows directly
// on the same entry. After reset a clearing sweep writes both tables, one entry
// per cycle, until every entry is written; busy stays high for that time and no
// transaction is taken. The receiver cannot stall: results are never held back.
module max_frequency_tracker #(
    parameter int SYMBOLS     = 1024,
    parameter int COUNT_LIMIT = 4095
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            mode,
    input  logic [mft_pkg::SYMBOL_W-1:0]    symbol,
    output logic                            done,
    output logic [mft_pkg::MAX_COUNT_W-1:0] max_count,
    output logic                            ignored
);
    import mft_pkg::*;

    localparam int AW      = $clog2(SYMBOLS);
    localparam int CW      = $clog2(COUNT_LIMIT + 1);
    localparam int PD      = (COUNT_LIMIT + 2) / 2;
    localparam int PAW     = (PD > 1) ? $clog2(PD) : 1;
    localparam int CLR_LEN = (SYMBOLS > PD) ? SYMBOLS : PD;
    localparam int CLW     = $clog2(CLR_LEN + 1);

    logic           clearing_reg;
    logic [CLW-1:0] clr_cnt_reg;
    logic [CLW-1:0] clr_cnt_next;
    logic           done_reg;
    logic           ignored_reg;
    logic [MAX_COUNT_W-1:0] max_count_reg;

    logic           accept;
    logic           sym_clr_en;
    logic           pop_clr_en;
    mft_ctl_t       s1_ctl;
    mft_ctl_t       s2_ctl;
    logic [CW-1:0]  c_cur;
    logic [CW-1:0]  c_new;
    logic [CW-1:0]  max_next;

    assign accept       = start && !clearing_reg;
    assign busy         = clearing_reg;
    assign clr_cnt_next = clr_cnt_reg + CLW'(1);
    assign sym_clr_en   = clearing_reg && (clr_cnt_reg < CLW'(SYMBOLS));
    assign pop_clr_en   = clearing_reg && (clr_cnt_reg < CLW'(PD));

    // Clearing sweep after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            clr_cnt_reg <= clr_cnt_next;
            if (clr_cnt_reg == CLW'(CLR_LEN - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // Symbol count lookup and step.
    mft_count_stage #(
        .SYMBOLS     (SYMBOLS),
        .COUNT_LIMIT (COUNT_LIMIT)
    ) u_count (
        .clk      (clk),
        .rst_n    (rst_n),
        .clr_en   (sym_clr_en),
        .clr_addr (AW'(clr_cnt_reg)),
        .in_valid (accept),
        .mode     (mode),
        .symbol   (symbol),
        .ctl      (s1_ctl),
        .c_cur    (c_cur),
        .c_new    (c_new)
    );

    // Population update and maximum tracking.
    mft_pop_stage #(
        .SYMBOLS     (SYMBOLS),
        .COUNT_LIMIT (COUNT_LIMIT)
    ) u_pop (
        .clk      (clk),
        .rst_n    (rst_n),
        .clr_en   (pop_clr_en),
        .clr_addr (PAW'(clr_cnt_reg)),
        .ctl      (s1_ctl),
        .c_cur    (c_cur),
        .c_new    (c_new),
        .res_ctl  (s2_ctl),
        .max_next (max_next)
    );

    // Result payload.
    always_ff @(posedge clk)
    begin
        max_count_reg <= MAX_COUNT_W'(max_next);
        ignored_reg   <= s2_ctl.ignored;
    end

    // Result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s2_ctl.valid;
        end
    end

    assign done      = done_reg;
    assign max_count = max_count_reg;
    assign ignored   = ignored_reg;

    // Every accepted transaction gives its result.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done)
        else $error("result missing three cycles after an accepted transaction");

    // Back-to-back results move the maximum by at most one.
    a_max_step: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(done)) |->
            ((max_count == $past(max_count)) ||
             (max_count == MAX_COUNT_W'($past(max_count) + 1'b1)) ||
             (max_count == MAX_COUNT_W'($past(max_count) - 1'b1))))
        else $error("maximum moved by more than one between results");

    // A dropped transaction leaves the maximum where it was.
    a_ignored_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ignored && $past(done)) |-> (max_count == $past(max_count)))
        else $error("maximum changed on an ignored transaction");

    // No result appears while the tables are being cleared.
    a_no_result_clear: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !done)
        else $error("result reported during the clearing sweep");

endmodule

// ===== tb/tb_max_frequency_tracker.sv =====
// Self-checking testbench for the max frequency tracker: directed, count-climb and random tests.
`timescale 1ns / 100ps

module tb_max_frequency_tracker;
    import mft_pkg::*;

    localparam int SYMBOLS       = 1024;
    localparam int COUNT_LIMIT   = 4095;
    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 8;
    localparam int REPORT_LIMIT  = 10;
    localparam int PHASE_ITEMS   = 190;
    localparam int CLIMB_HEIGHT  = 150;

    // Operation carried by the mode port.
    typedef enum bit {
        OP_REMOVE = 1'b0,
        OP_INSERT = 1'b1
    } op_t;

    // One result as the block reports it.
    typedef struct packed {
        logic [MAX_COUNT_W-1:0] max_count;
        logic                   ignored;
    } freq_result_t;

    logic                   clk    = 1'b0;
    logic                   rst_n  = 1'b0;
    logic                   start  = 1'b0;
    logic                   mode   = 1'b0;
    logic [SYMBOL_W-1:0]    symbol = '0;
    logic                   busy;
    logic                   done;
    logic [MAX_COUNT_W-1:0] max_count;
    logic                   ignored;

    // Multiset shadow: count per symbol, symbols per count, and the mode frequency.
    logic [MAX_COUNT_W-1:0] sym_tally [SYMBOLS];
    int unsigned            tally_census [COUNT_LIMIT+1];
    logic [MAX_COUNT_W-1:0] mode_freq;

    freq_result_t           pending_freqs [$];
    int                     idle_pct;
    int                     mismatches = 0;

    max_frequency_tracker #(
        .SYMBOLS     (SYMBOLS),
        .COUNT_LIMIT (COUNT_LIMIT)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .mode      (mode),
        .symbol    (symbol),
        .done      (done),
        .max_count (max_count),
        .ignored   (ignored)
    );

    always #CLK_HALF clk = ~clk;

    // Applies one transaction to the shadow multiset and returns the expected result.
    function automatic freq_result_t step_tracker(op_t op, logic [SYMBOL_W-1:0] sym);
        freq_result_t res;
        int           cnt;
        cnt = int'(sym_tally[sym]);
        res.ignored = 1'b0;
        if (op == OP_INSERT)
        begin
            if (cnt >= COUNT_LIMIT)
            begin
                res.ignored = 1'b1;
            end
            else
            begin
                tally_census[cnt]--;
                cnt++;
                tally_census[cnt]++;
                sym_tally[sym] = MAX_COUNT_W'(cnt);
                if (cnt > int'(mode_freq))
                    mode_freq = MAX_COUNT_W'(cnt);
            end
        end
        else
        begin
            if (cnt == 0)
            begin
                res.ignored = 1'b1;
            end
            else
            begin
                tally_census[cnt]--;
                cnt--;
                tally_census[cnt]++;
                sym_tally[sym] = MAX_COUNT_W'(cnt);
                // The maximum drops only when no symbol is left at the old maximum.
                if (mode_freq > 0 && tally_census[mode_freq] == 0)
                    mode_freq--;
            end
        end
        res.max_count = mode_freq;
        return res;
    endfunction

    function automatic void note_mismatch(string what);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("[%0t] %s", $realtime, what);
    endfunction

    // Sends one transaction, with random idle cycles ahead of it, and queues its expected result.
    task automatic send_transaction(op_t op, logic [SYMBOL_W-1:0] sym);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start  <= 1'b1;
        mode   <= op;
        symbol <= sym;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_freqs.push_back(step_tracker(op, sym));
    endtask

    // Holds the sender off until every expected result has come back.
    task automatic drain_results();
        start <= 1'b0;
        while (pending_freqs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Removal of absent symbols, back-to-back updates, rise and fall of the maximum.
    task automatic test_directed();
        idle_pct = 0;
        send_transaction(OP_REMOVE, 10'h000);
        repeat (3) send_transaction(OP_INSERT, 10'h000);
        send_transaction(OP_INSERT, 10'h3FF);
        send_transaction(OP_INSERT, 10'h2AA);
        send_transaction(OP_INSERT, 10'h155);
        send_transaction(OP_REMOVE, 10'h000);
        send_transaction(OP_INSERT, 10'h3FF);
        send_transaction(OP_REMOVE, 10'h000);
        send_transaction(OP_REMOVE, 10'h3FF);
        send_transaction(OP_REMOVE, 10'h000);
        send_transaction(OP_REMOVE, 10'h000);
        send_transaction(OP_REMOVE, 10'h3FF);
        send_transaction(OP_REMOVE, 10'h2AA);
        send_transaction(OP_REMOVE, 10'h155);
        send_transaction(OP_REMOVE, 10'h155);
        drain_results();
    endtask

    // Drives one symbol to a tall count, steps it down and up, then empties it again.
    task automatic test_count_climb();
        idle_pct = 10;
        repeat (CLIMB_HEIGHT) send_transaction(OP_INSERT, 10'h0F0);
        send_transaction(OP_REMOVE, 10'h0F0);
        send_transaction(OP_INSERT, 10'h0F0);
        send_transaction(OP_INSERT, 10'h0F0);
        repeat (CLIMB_HEIGHT + 1) send_transaction(OP_REMOVE, 10'h0F0);
        send_transaction(OP_REMOVE, 10'h0F0);
        drain_results();
    endtask

    // Random traffic, mostly on a small symbol pool so that counts build up and fall.
    task automatic test_random_traffic();
        int                  phase_idle [3];
        int                  phase_insert [3];
        op_t                 op;
        logic [SYMBOL_W-1:0] sym;
        phase_idle   = '{0, 58, 10};
        phase_insert = '{65, 50, 35};
        for (int p = 0; p < 3; p++)
        begin
            idle_pct = phase_idle[p];
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                op  = ($urandom_range(99) < phase_insert[p]) ? OP_INSERT : OP_REMOVE;
                sym = ($urandom_range(99) < 75) ? SYMBOL_W'($urandom_range(15))
                                                : SYMBOL_W'($urandom_range(SYMBOLS-1));
                send_transaction(op, sym);
            end
            drain_results();
        end
    endtask

    // Compares each result with the oldest expectation.
    always @(posedge clk)
    begin : result_check
        freq_result_t want;
        if (rst_n && done)
        begin
            if (pending_freqs.size() == 0)
            begin
                note_mismatch($sformatf("unexpected result max_count=%0d ignored=%0b",
                                        max_count, ignored));
            end
            else
            begin
                want = pending_freqs.pop_front();
                if (want.max_count !== max_count || want.ignored !== ignored)
                    note_mismatch($sformatf("expected max_count=%0d ignored=%0b, got %0d %0b",
                                            want.max_count, want.ignored,
                                            max_count, ignored));
            end
        end
    end

    // Guards against a hung handshake.
    initial
    begin
        #5ms;
        $display("Timeout: transactions or results stalled.");
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        for (int s = 0; s < SYMBOLS; s++)
            sym_tally[s] = '0;
        for (int c = 0; c <= COUNT_LIMIT; c++)
            tally_census[c] = 0;
        tally_census[0] = SYMBOLS;
        mode_freq = '0;
        idle_pct  = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_count_climb();
        test_random_traffic();
        drain_results();

        if (mismatches == 0 && pending_freqs.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
